// File: src/line_vector_steering_core_macros.svh
// Assertion macros used by the rotation cell of the steering core.
`ifndef LINE_VECTOR_STEERING_CORE_MACROS_SVH
`define LINE_VECTOR_STEERING_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checks an expression at every clock edge outside reset.
`define LVS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define LVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LVS_ASSERT(lbl, prop, msg)
`define LVS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/lvs_pkg.sv
// Shared types, constants and the arctangent table of the steering core.
package lvs_pkg;

	localparam int CORDIC_STAGES = 16;

	// Datapath widths: rotation vector, angle accumulator, rounded angle.
	localparam int XW   = 28;
	localparam int ZW   = 26;
	localparam int AW   = ZW - 8;
	localparam int IDXW = 5;

	// Fixed line origin used when two or more vectors are seen.
	localparam logic [7:0] LINE_ORIGIN_X = 8'd39;
	localparam logic [7:0] LINE_ORIGIN_Y = 8'd51;

	// Half turn in accumulator units.
	localparam logic signed [ZW-1:0] PI_UNITS = 26'sd12353245;

	// Register indexes.
	localparam logic [2:0] REG_LIMIT_RIGHT    = 3'd0;
	localparam logic [2:0] REG_LIMIT_LEFT     = 3'd1;
	localparam logic [2:0] REG_STEER_OFFSET   = 3'd2;
	localparam logic [2:0] REG_SLOW_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_FAST_SPEED     = 3'd4;
	localparam logic [2:0] REG_SLOW_SPEED     = 3'd5;

	// One vector and its angle as it moves from cell to cell.
	typedef struct packed {
		logic                 valid;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} lvs_stage_t;

	// Register file contents.
	typedef struct packed {
		logic signed [16:0] limit_right;
		logic signed [16:0] limit_left;
		logic signed [16:0] steer_offset;
		logic [15:0]        slow_threshold;
		logic [7:0]         fast_speed;
		logic [7:0]         slow_speed;
	} lvs_cfg_t;

	// Rotation angle of each stage in accumulator units.
	function automatic logic signed [ZW-1:0] atan_unit(input logic [IDXW-1:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0:    v = 26'sd3088311;
			5'd1:    v = 26'sd1823137;
			5'd2:    v = 26'sd963295;
			5'd3:    v = 26'sd488984;
			5'd4:    v = 26'sd245441;
			5'd5:    v = 26'sd122840;
			5'd6:    v = 26'sd61435;
			5'd7:    v = 26'sd30719;
			5'd8:    v = 26'sd15360;
			5'd9:    v = 26'sd7680;
			5'd10:   v = 26'sd3840;
			5'd11:   v = 26'sd1920;
			5'd12:   v = 26'sd960;
			5'd13:   v = 26'sd480;
			5'd14:   v = 26'sd240;
			5'd15:   v = 26'sd120;
			5'd16:   v = 26'sd60;
			5'd17:   v = 26'sd30;
			5'd18:   v = 26'sd15;
			5'd19:   v = 26'sd8;
			5'd20:   v = 26'sd4;
			5'd21:   v = 26'sd2;
			5'd22:   v = 26'sd1;
			default: v = 26'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/lvs_front.sv
// Entry cell: picks the line, forms the vector and turns it into the right half plane.
module lvs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          vector_count,
	input  logic [7:0]          first_tail_x,
	input  logic [7:0]          first_tail_y,
	input  logic [7:0]          first_head_x,
	input  logic [7:0]          first_head_y,
	input  logic [7:0]          second_head_x,
	input  logic [7:0]          second_head_y,
	input  logic                out_ready,
	output lvs_pkg::lvs_stage_t out_stage
);
	import lvs_pkg::*;

	logic [7:0]           x0, y0, x1, y1;
	logic [8:0]           mid_x_sum, mid_y_sum;
	logic signed [9:0]    dx, dy;
	logic signed [XW-1:0] x_raw, y_raw, x_rot, y_rot;
	logic signed [ZW-1:0] z_rot;

	logic                 v_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;

	// Line endpoints from the vector count.
	always_comb begin
		mid_x_sum = {1'b0, first_head_x} + {1'b0, second_head_x};
		mid_y_sum = {1'b0, first_head_y} + {1'b0, second_head_y};
		if (vector_count >= 2'd2) begin
			x0 = LINE_ORIGIN_X;
			y0 = LINE_ORIGIN_Y;
			x1 = mid_x_sum[8:1];
			y1 = mid_y_sum[8:1];
		end else if (vector_count == 2'd1) begin
			x0 = first_tail_x;
			y0 = first_tail_y;
			x1 = first_head_x;
			y1 = first_head_y;
		end else begin
			x0 = '0;
			y0 = '0;
			x1 = '0;
			y1 = '0;
		end
	end

	// Vector in accumulator scale, turned by a half turn when it points down.
	always_comb begin
		dx    = $signed({2'b00, x1}) - $signed({2'b00, x0});
		dy    = $signed({2'b00, y0}) - $signed({2'b00, y1});
		x_raw = XW'(dy) <<< 16;
		y_raw = XW'(dx) <<< 16;
		if (x_raw < 0) begin
			z_rot = (dx >= 0) ? PI_UNITS : -PI_UNITS;
			x_rot = -x_raw;
			y_rot = -y_raw;
		end else begin
			z_rot = '0;
			x_rot = x_raw;
			y_rot = y_raw;
		end
	end

	assign in_ready = !v_s1 || out_ready;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1 <= x_rot;
			y_s1 <= y_rot;
			z_s1 <= z_rot;
		end
	end

	assign out_stage = '{valid: v_s1, x: x_s1, y: y_s1, z: z_s1};

endmodule

// File: src/lvs_cordic_cell.sv
// One vectoring rotation of the arctangent chain.
`include "line_vector_steering_core_macros.svh"
module lvs_cordic_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [4:0]          stage_idx,
	input  lvs_pkg::lvs_stage_t in_stage,
	output logic                in_ready,
	input  logic                out_ready,
	output lvs_pkg::lvs_stage_t out_stage
);
	import lvs_pkg::*;

	logic                 load;
	logic signed [XW-1:0] xs, ys, x_next, y_next;
	logic signed [ZW-1:0] z_next, step;

	logic                 v_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	// Rotate toward the x axis; a zero residue passes through unchanged.
	always_comb begin
		xs   = in_stage.x >>> stage_idx;
		ys   = in_stage.y >>> stage_idx;
		step = atan_unit(stage_idx);
		if (in_stage.y == '0) begin
			x_next = in_stage.x;
			y_next = in_stage.y;
			z_next = in_stage.z;
		end else if (in_stage.y > 0) begin
			x_next = in_stage.x + ys;
			y_next = in_stage.y - xs;
			z_next = in_stage.z + step;
		end else begin
			x_next = in_stage.x - ys;
			y_next = in_stage.y + xs;
			z_next = in_stage.z - step;
		end
	end

	assign in_ready = !v_q || out_ready;
	assign load     = in_ready && in_stage.valid;

	// Cell valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_stage.valid;
		end
	end

	// Cell payload.
	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_next;
			y_q <= y_next;
			z_q <= z_next;
		end
	end

	assign out_stage = '{valid: v_q, x: x_q, y: y_q, z: z_q};

	// The rotated x stays non-negative; a sign flip means the datapath overflowed.
	`LVS_ASSERT(x_nonneg_a, !v_q || !x_q[XW-1], "cordic x went negative")
	// A zero residue must leave the angle as it was.
	`LVS_ASSERT_NEXT(zero_hold_a, load && in_stage.y == '0, z_q == $past(in_stage.z) && y_q == '0,
		"zero residue changed the angle")
	// A held item is not dropped while the next cell is busy.
	`LVS_ASSERT_NEXT(stall_hold_a, v_q && !out_ready, v_q && $stable(z_q),
		"stalled cell lost its item")

endmodule

// File: src/lvs_post.sv
// Output cell: rounds the angle, clamps it, adds the offset and picks the speed.
module lvs_post (
	input  logic                clk,
	input  logic                arst_n,
	input  lvs_pkg::lvs_stage_t in_stage,
	output logic                in_ready,
	input  lvs_pkg::lvs_cfg_t   cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [17:0]         steer_out,
	output logic [16:0]         clamp_angle,
	output logic [7:0]          motor_speed
);
	import lvs_pkg::*;

	logic signed [ZW-1:0] z_rnd;
	logic signed [AW-1:0] a_rnd, a_clamp, a_mag, lim_r, lim_l;
	logic signed [16:0]   ref_next;
	logic signed [17:0]   steer_next;
	logic [7:0]           speed_next;

	logic                 v_q;
	logic [17:0]          steer_q;
	logic [16:0]          ref_q;
	logic [7:0]           speed_q;

	// Round off the low 8 bits of the angle, clamp with the right limit taking priority.
	always_comb begin
		z_rnd = in_stage.z + ZW'(128);
		a_rnd = z_rnd[ZW-1:8];
		lim_r = AW'(cfg.limit_right);
		lim_l = AW'(cfg.limit_left);
		if (a_rnd > lim_r) begin
			a_clamp = lim_r;
		end else if (a_rnd < lim_l) begin
			a_clamp = lim_l;
		end else begin
			a_clamp = a_rnd;
		end
		ref_next   = a_clamp[16:0];
		steer_next = 18'(ref_next) + 18'(cfg.steer_offset);
		a_mag      = (a_clamp < 0) ? -a_clamp : a_clamp;
		speed_next = (a_mag[16:0] >= {1'b0, cfg.slow_threshold}) ? cfg.slow_speed
			: cfg.fast_speed;
	end

	assign in_ready = !v_q || out_ready;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_stage.valid;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_stage.valid) begin
			steer_q <= steer_next;
			ref_q   <= ref_next;
			speed_q <= speed_next;
		end
	end

	assign out_valid   = v_q;
	assign steer_out   = steer_q;
	assign clamp_angle = ref_q;
	assign motor_speed = speed_q;

endmodule

// File: src/line_vector_steering_core.sv
// Top level of the steering core: register file and the chain of cells.
//
// Channel   Dir  Handshake                  Contents
// s_axis    in   s_axis_tvalid/tready       one camera frame of line vectors
// m_axis    out  m_axis_tvalid/tready       steering angle, reference angle, speed
// apb       in   psel/penable/pwrite/pready register writes and reads
//
// Items pass through the entry cell, one cell per rotation, and the output register.
// One transfer is taken in every cycle while s_axis_tready is high; each cell
// moves its item on whenever the next cell is free, so gaps close up.
// A stall on m_axis backs up cell by cell to s_axis_tready.
// Reset clears the valid flags and loads the register defaults; no sweep follows.
module line_vector_steering_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] first_tail_x, [15:8] first_tail_y, [23:16] first_head_x,
	// [31:24] first_head_y, [39:32] second_head_x, [47:40] second_head_y
	input  logic [47:0] s_axis_tdata,
	// [1:0] vector_count
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [17:0] steer_out, [34:18] clamp_angle, [42:35] motor_speed, [47:43] zero
	output logic [47:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lvs_pkg::*;

	lvs_cfg_t                 cfg_q;
	logic                     cfg_wr;
	lvs_stage_t               stage [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0]   stage_rdy;
	logic [17:0]              steer_out;
	logic [16:0]              clamp_angle;
	logic [7:0]               motor_speed;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_right    <= 17'sd7680;
			cfg_q.limit_left     <= -17'sd7680;
			cfg_q.steer_offset   <= 17'sd0;
			cfg_q.slow_threshold <= 16'd2560;
			cfg_q.fast_speed     <= 8'd100;
			cfg_q.slow_speed     <= 8'd25;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_LIMIT_RIGHT:    cfg_q.limit_right    <= pwdata[16:0];
				REG_LIMIT_LEFT:     cfg_q.limit_left     <= pwdata[16:0];
				REG_STEER_OFFSET:   cfg_q.steer_offset   <= pwdata[16:0];
				REG_SLOW_THRESHOLD: cfg_q.slow_threshold <= pwdata[15:0];
				REG_FAST_SPEED:     cfg_q.fast_speed     <= pwdata[7:0];
				REG_SLOW_SPEED:     cfg_q.slow_speed     <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads, signed registers sign-extended.
	always_comb begin
		unique case (paddr[4:2])
			REG_LIMIT_RIGHT:    prdata = 32'(cfg_q.limit_right);
			REG_LIMIT_LEFT:     prdata = 32'(cfg_q.limit_left);
			REG_STEER_OFFSET:   prdata = 32'(cfg_q.steer_offset);
			REG_SLOW_THRESHOLD: prdata = {16'd0, cfg_q.slow_threshold};
			REG_FAST_SPEED:     prdata = {24'd0, cfg_q.fast_speed};
			REG_SLOW_SPEED:     prdata = {24'd0, cfg_q.slow_speed};
			default:            prdata = '0;
		endcase
	end

	// Entry cell.
	lvs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.vector_count  (s_axis_tuser),
		.first_tail_x  (s_axis_tdata[7:0]),
		.first_tail_y  (s_axis_tdata[15:8]),
		.first_head_x  (s_axis_tdata[23:16]),
		.first_head_y  (s_axis_tdata[31:24]),
		.second_head_x (s_axis_tdata[39:32]),
		.second_head_y (s_axis_tdata[47:40]),
		.out_ready     (stage_rdy[0]),
		.out_stage     (stage[0])
	);

	// Rotation cells.
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		lvs_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_idx (IDXW'(g)),
			.in_stage  (stage[g]),
			.in_ready  (stage_rdy[g]),
			.out_ready (stage_rdy[g+1]),
			.out_stage (stage[g+1])
		);
	end

	// Output cell.
	lvs_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_stage    (stage[CORDIC_STAGES]),
		.in_ready    (stage_rdy[CORDIC_STAGES]),
		.cfg         (cfg_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.steer_out   (steer_out),
		.clamp_angle (clamp_angle),
		.motor_speed (motor_speed)
	);

	assign m_axis_tdata = {5'd0, motor_speed, clamp_angle, steer_out};

endmodule
